/* sv/ggpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggpc_pkg
// Shared types and codes of the guarded gpio pin controller.
// ----------------------------------------------------------------------------
package ggpc_pkg;

  localparam int CMD_W = 3;
  localparam int PIN_W = 6;
  localparam int ST_W  = 2;
  localparam int DIR_W = 2;

  localparam logic [CMD_W-1:0] CMD_GET_VALUE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_VALUE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MAKE_INPUT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MAKE_OUTPUT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET_FUNCTION = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
  localparam logic [ST_W-1:0] ST_DENIED  = 2'd2;

  localparam logic [DIR_W-1:0] DIR_INPUT  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_OUTPUT = 2'd1;

  localparam logic [PIN_W-1:0] PIN_INPUT_ONLY = 6'd0;
  localparam logic [PIN_W-1:0] PIN_DRIVE_A    = 6'd19;
  localparam logic [PIN_W-1:0] PIN_DRIVE_B    = 6'd34;
  localparam logic [PIN_W-1:0] PIN_DRIVE_C    = 6'd35;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [PIN_W-1:0] pin;
    logic             level;
  } cmd_item_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic            read_level;
    logic            is_output;
  } rsp_item_t;

endpackage

/* sv/ggpc_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggpc_stream_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface ggpc_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

/* sv/ggpc_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggpc_stage
// Register slice: holds one item, refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module ggpc_stage #(
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  logic  valid;
  item_t item;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

/* sv/ggpc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggpc_core
// Pin stores and command decode: answers one command and updates the stores.
// ----------------------------------------------------------------------------
module ggpc_core #(
  parameter int PIN_COUNT = 50
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  ggpc_pkg::cmd_item_t item,
  output ggpc_pkg::rsp_item_t result
);
  import ggpc_pkg::*;

  localparam int IDX_W = $clog2(PIN_COUNT);

  logic [PIN_COUNT-1:0]            data_bits;
  logic [PIN_COUNT-1:0][DIR_W-1:0] dir_fields;

  logic             pin_ok;
  logic             drivable;
  logic [IDX_W-1:0] idx;
  logic             cur_data;
  logic [DIR_W-1:0] cur_dir;
  logic             wr_data;
  logic             wr_dir;

  assign idx      = item.pin[IDX_W-1:0];
  assign pin_ok   = ({1'b0, item.pin} < 7'(PIN_COUNT));
  assign drivable = (item.pin == PIN_DRIVE_A) || (item.pin == PIN_DRIVE_B) ||
                    (item.pin == PIN_DRIVE_C);
  assign cur_data = pin_ok ? data_bits[idx] : 1'b0;
  assign cur_dir  = pin_ok ? dir_fields[idx] : DIR_INPUT;

  always_comb begin
    result.status     = ST_INVALID;
    result.read_level = 1'b0;
    result.is_output  = 1'b0;
    wr_data           = 1'b0;
    wr_dir            = 1'b0;
    case (item.cmd)
      CMD_GET_VALUE: begin
        if (pin_ok) begin
          result.status     = ST_OK;
          result.read_level = cur_data;
        end
      end
      CMD_SET_VALUE: begin
        if (!drivable) begin
          result.status = ST_DENIED;
        end else if (pin_ok) begin
          result.status = ST_OK;
          wr_data       = 1'b1;
        end
      end
      CMD_MAKE_INPUT: begin
        result.status = (item.pin == PIN_INPUT_ONLY) ? ST_OK : ST_DENIED;
      end
      CMD_MAKE_OUTPUT: begin
        if (!drivable) begin
          result.status = ST_DENIED;
        end else if (pin_ok) begin
          result.status = ST_OK;
          wr_data       = 1'b1;
          wr_dir        = 1'b1;
        end
      end
      CMD_GET_FUNCTION: begin
        if (item.pin == PIN_INPUT_ONLY) begin
          result.status = ST_OK;
        end else if (pin_ok && (cur_dir == DIR_INPUT || cur_dir == DIR_OUTPUT)) begin
          result.status    = ST_OK;
          result.is_output = (cur_dir == DIR_OUTPUT);
        end
      end
      default: begin
        result.status = ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_bits  <= '0;
      dir_fields <= '0;
    end else if (fire) begin
      if (wr_data) begin
        data_bits[idx] <= item.level;
      end
      if (wr_dir) begin
        dir_fields[idx] <= DIR_OUTPUT;
      end
    end
  end

endmodule

/* sv/guarded_gpio_pin_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// guarded_gpio_pin_controller_top
// Gpio pin controller with per-pin command guards.
// Result path: input stage register, combinational core decode, output stage register.
// Throughput: one item per cycle while the result channel is not stalled; stores are read and written in one pass.
// Reset: synchronous; clears the valid flags of both stages and all pin stores to zero.
// ----------------------------------------------------------------------------
module guarded_gpio_pin_controller_top #(
  parameter int PIN_COUNT = 50
) (
  input logic          clk,
  input logic          rst,
  ggpc_stream_if.sink   req,
  ggpc_stream_if.source rsp
);
  import ggpc_pkg::*;

  logic      s1_valid;
  logic      s1_ready;
  cmd_item_t s1_item;
  rsp_item_t s1_result;

  ggpc_stage #(.item_t(cmd_item_t)) u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_item   (req.item),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_item  (s1_item)
  );

  ggpc_core #(.PIN_COUNT(PIN_COUNT)) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (s1_valid && s1_ready),
    .item   (s1_item),
    .result (s1_result)
  );

  ggpc_stage #(.item_t(rsp_item_t)) u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_item   (s1_result),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_item  (rsp.item)
  );

endmodule

/* sv/ggpc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggpc_checker
// Port-level checks on the result channel of the gpio controller.
// ----------------------------------------------------------------------------
module ggpc_checker (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input ggpc_pkg::rsp_item_t rsp_item
);
  import ggpc_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
    else $error("result item dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_item.status == ST_OK || rsp_item.status == ST_INVALID ||
                   rsp_item.status == ST_DENIED))
    else $error("undefined status code");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.status != ST_OK |-> !rsp_item.read_level && !rsp_item.is_output)
    else $error("data flags set on failed command");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_item.read_level && rsp_item.is_output))
    else $error("read level and function flag both set");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind guarded_gpio_pin_controller_top ggpc_checker u_ggpc_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_item  (rsp.item)
);
